@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the line-fit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant that must hold at every sampled edge out of reset.
`define TLS_CHECK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define TLS_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/core/tls_pkg.sv @@
// Shared types and constants for the total least squares line fit.
package tls_pkg;

  // Divider divisor width and square root radicand/root widths.
  localparam int DEN_W      = 32;
  localparam int SQ_W       = 64;
  localparam int ROOT_W     = 32;
  // Direction vector format: Q1.30.
  localparam int DIR_FRAC   = 30;
  localparam logic [31:0] DIR_ONE    = 32'h4000_0000;
  localparam logic [31:0] ROUND_HALF = 32'h2000_0000;
  localparam logic [31:0] SAT32      = 32'hFFFF_FFFF;
  // Moments are scaled so the largest lies in [2^27, 2^28).
  localparam int SCALE_BITS = 28;
  // Perpendicular distance width.
  localparam int D_W        = 34;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_MEAN_X,
    ST_MEAN_Y,
    ST_MOM,
    ST_SCALE,
    ST_SQ,
    ST_DISC_GO,
    ST_DISC,
    ST_VEC,
    ST_VSQ,
    ST_NORM_GO,
    ST_NORM,
    ST_UX,
    ST_UY,
    ST_RES,
    ST_RMS_DIV,
    ST_RMS_SQRT,
    ST_FIN
  } tls_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

@@ rtl/core/total_least_squares_line_fit.sv @@
// Total least squares line fit over a run of 2D points (top level).
// Points arrive one item per cycle in signed Q16.16 and are written to an on-chip point store
// while running x and y sums are kept; a point with last_point set closes the run. The block
// then stops taking items and fits: two serial divides give the rounded centroid, a streamed
// pass over the store accumulates the centred moments Sxx, Syy and Sxy, the moments are
// normalized one bit per cycle into [2^27, 2^28), two serial square roots and two divides give
// the unit direction in Q1.30, and a second streamed pass accumulates the squared and maximum
// perpendicular distances. A final divide and square root give the RMS distance. The fit time
// is set by the two memory passes (one read per cycle from the single store port) and the
// bit-serial divider, which dominates for short runs. Runs of fewer than two points skip the
// fit and report fit_ok low. Points past MAX_POINTS are dropped and flagged as truncated. The
// result item waits in an output register; new points are taken while it waits, but the next
// fit cannot finish until that result has been taken.
`include "assert_macros.svh"

module total_least_squares_line_fit #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [31:0]                 in_x_coord,
  input  logic signed [31:0]                 in_y_coord,
  input  logic                               in_last_point,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_fit_ok,
  output logic signed [31:0]                 out_centroid_x,
  output logic signed [31:0]                 out_centroid_y,
  output logic signed [31:0]                 out_dir_x,
  output logic signed [31:0]                 out_dir_y,
  output logic [31:0]                        out_rms_dev,
  output logic [31:0]                        out_max_dev,
  output logic [$clog2(MAX_POINTS+1)-1:0]    out_point_count,
  output logic                               out_truncated
);
  import tls_pkg::*;

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = 32 + AW;   // running coordinate sums
  localparam int ACC_W = 65 + AW;   // moment accumulators
  localparam int NW    = 68 + AW;   // squared distance sum, divider dividend

  // ---------------------------------------------------------------- helpers
  function automatic logic [NW-1:0] mean_num(input logic signed [SUM_W-1:0] s,
                                             input logic [CNT_W-1:0] n);
    logic [SUM_W-1:0] m;
    m = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
    return NW'(m) + NW'(n >> 1);
  endfunction

  // Clamp a unit component to 2^30 and apply its sign.
  function automatic logic signed [31:0] unit_fix(input logic [NW-1:0] q, input logic neg);
    logic [31:0] m;
    m = (q > NW'(DIR_ONE)) ? DIR_ONE : q[31:0];
    return neg ? -signed'(m) : signed'(m);
  endfunction

  // ---------------------------------------------------------------- state
  tls_state_t              state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [SUM_W-1:0] sum_x_r, sum_y_r;
  logic                    ovf_r;

  logic signed [31:0]      mx_r, my_r;
  logic signed [31:0]      dir_x_r, dir_y_r;
  logic [31:0]             rms_r;

  // pass pipeline
  logic [CNT_W-1:0]        issue_cnt_r;
  logic                    p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [32:0]      dx_r, dy_r;
  logic [65:0]             pxx_r, pyy_r;
  logic signed [65:0]      pxy_r;
  logic signed [64:0]      pa_r, pb_r;
  logic [D_W-1:0]          d_r, worst_r;
  logic [2*D_W-1:0]        dsq_r;
  logic [ACC_W-1:0]        sxx_r, syy_r;
  logic signed [ACC_W-1:0] sxy_r;
  logic [NW-1:0]           ssq_r;

  // direction
  logic [ACC_W-1:0]        a_r, b_r, c_r;
  logic                    cneg_r;
  logic [57:0]             dd_r;
  logic [55:0]             csq_r;
  logic [31:0]             disc_r, norm_r;
  logic signed [32:0]      vx_r, vy_r;
  logic [63:0]             vxsq_r, vysq_r;

  // output register
  logic                    out_valid_r;
  logic                    o_ok_r, o_trunc_r;
  logic signed [31:0]      o_cx_r, o_cy_r, o_dx_r, o_dy_r;
  logic [31:0]             o_rms_r, o_max_r;
  logic [CNT_W-1:0]        o_cnt_r;

  // ---------------------------------------------------------------- units
  logic                    div_start;
  logic [NW-1:0]           div_num;
  logic [DEN_W-1:0]        div_den;
  logic [NW-1:0]           div_quo;
  unit_sts_t               div_sts;
  logic                    sqrt_start;
  logic [SQ_W-1:0]         sqrt_in;
  logic [ROOT_W-1:0]       sqrt_root;
  unit_sts_t               sqrt_sts;

  logic                    in_acc;
  logic                    mem_we, mem_re;
  logic [63:0]             rd_data;
  logic signed [31:0]      rd_x, rd_y;

  tls_mem #(.DEPTH(MAX_POINTS), .AW(AW), .DW(64)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata ({in_x_coord, in_y_coord}),
    .re    (mem_re),
    .raddr (issue_cnt_r[AW-1:0]),
    .rdata (rd_data)
  );

  tls_div #(.NW(NW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .sts   (div_sts)
  );

  tls_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (sqrt_in),
    .root  (sqrt_root),
    .sts   (sqrt_sts)
  );

  // ---------------------------------------------------------------- comb datapath
  logic                    pass_on, pipe_busy, pass_done;
  logic [32:0]             ux, uy;
  logic signed [65:0]      pdiff;
  logic [65:0]             pm, pr;
  logic [ACC_W-1:0]        sxy_mag, or_all;
  logic                    czero, scale_hi, scale_ok;
  logic signed [28:0]      diff;
  logic signed [32:0]      two_c, disc_s, diff_s, vt, vx_c, vy_c;
  logic [31:0]             vxm, vym;
  logic                    store_ok;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign store_ok  = cnt_r < CNT_W'(MAX_POINTS);
  assign mem_we    = in_acc && store_ok;
  assign rd_x      = signed'(rd_data[63:32]);
  assign rd_y      = signed'(rd_data[31:0]);

  assign pass_on   = (state_r == ST_MOM) || (state_r == ST_RES);
  assign pipe_busy = p1_r || p2_r || p3_r || p4_r || p5_r;
  assign pass_done = pass_on && (issue_cnt_r == cnt_r) && !pipe_busy;
  assign mem_re    = pass_on && (issue_cnt_r != cnt_r);

  always_comb begin
    ux      = dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
    uy      = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);
    // perpendicular distance, rounded back to the coordinate format
    pdiff   = 66'(pa_r) - 66'(pb_r);
    pm      = pdiff[65] ? 66'(-pdiff) : 66'(pdiff);
    pr      = pm + 66'(ROUND_HALF);
    sxy_mag = sxy_r[ACC_W-1] ? ACC_W'(-sxy_r) : ACC_W'(sxy_r);
    czero   = (sxy_r == '0);
    or_all  = a_r | b_r | c_r;
    scale_hi = |or_all[ACC_W-1:SCALE_BITS];
    scale_ok = !scale_hi && or_all[SCALE_BITS-1];
    diff    = signed'({1'b0, a_r[SCALE_BITS-1:0]}) - signed'({1'b0, b_r[SCALE_BITS-1:0]});
    two_c   = signed'(33'({c_r[SCALE_BITS-1:0], 1'b0}));
    disc_s  = signed'(33'(disc_r));
    diff_s  = 33'(diff);
    vt      = disc_s - diff_s;
    if (!diff[28]) begin
      vx_c = diff_s + disc_s;
      vy_c = cneg_r ? -two_c : two_c;
    end else begin
      vx_c = two_c;
      vy_c = cneg_r ? -vt : vt;
    end
    vxm     = vx_r[32] ? 32'(-vx_r) : 32'(vx_r);
    vym     = vy_r[32] ? 32'(-vy_r) : 32'(vy_r);
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    sqrt_start = 1'b0;
    sqrt_in    = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_last_point) state_nxt = ST_START;
      end
      ST_START: begin
        if (cnt_r < CNT_W'(2)) begin
          state_nxt = ST_FIN;
        end else begin
          div_start = 1'b1;
          div_num   = mean_num(sum_x_r, cnt_r);
          div_den   = DEN_W'(cnt_r);
          state_nxt = ST_MEAN_X;
        end
      end
      ST_MEAN_X: begin
        if (div_sts.done) begin
          div_start = 1'b1;
          div_num   = mean_num(sum_y_r, cnt_r);
          div_den   = DEN_W'(cnt_r);
          state_nxt = ST_MEAN_Y;
        end
      end
      ST_MEAN_Y: begin
        if (div_sts.done) state_nxt = ST_MOM;
      end
      ST_MOM: begin
        if (pass_done) state_nxt = czero ? ST_RES : ST_SCALE;
      end
      ST_SCALE: begin
        if (scale_ok) state_nxt = ST_SQ;
      end
      ST_SQ: state_nxt = ST_DISC_GO;
      ST_DISC_GO: begin
        sqrt_start = 1'b1;
        sqrt_in    = 64'(dd_r) + 64'({csq_r, 2'b00});
        state_nxt  = ST_DISC;
      end
      ST_DISC: begin
        if (sqrt_sts.done) state_nxt = ST_VEC;
      end
      ST_VEC: state_nxt = ST_VSQ;
      ST_VSQ: state_nxt = ST_NORM_GO;
      ST_NORM_GO: begin
        sqrt_start = 1'b1;
        sqrt_in    = vxsq_r + vysq_r;
        state_nxt  = ST_NORM;
      end
      ST_NORM: begin
        if (sqrt_sts.done) begin
          if (sqrt_root == '0) begin
            state_nxt = ST_RES;
          end else begin
            div_start = 1'b1;
            div_num   = (NW'(vxm) << DIR_FRAC) + NW'(sqrt_root >> 1);
            div_den   = sqrt_root;
            state_nxt = ST_UX;
          end
        end
      end
      ST_UX: begin
        if (div_sts.done) begin
          div_start = 1'b1;
          div_num   = (NW'(vym) << DIR_FRAC) + NW'(norm_r >> 1);
          div_den   = norm_r;
          state_nxt = ST_UY;
        end
      end
      ST_UY: begin
        if (div_sts.done) state_nxt = ST_RES;
      end
      ST_RES: begin
        if (pass_done) begin
          div_start = 1'b1;
          div_num   = ssq_r;
          div_den   = DEN_W'(cnt_r);
          state_nxt = ST_RMS_DIV;
        end
      end
      ST_RMS_DIV: begin
        if (div_sts.done) begin
          if (|div_quo[NW-1:SQ_W]) begin
            state_nxt = ST_FIN;
          end else begin
            sqrt_start = 1'b1;
            sqrt_in    = div_quo[SQ_W-1:0];
            state_nxt  = ST_RMS_SQRT;
          end
        end
      end
      ST_RMS_SQRT: begin
        if (sqrt_sts.done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- run control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      ovf_r       <= 1'b0;
      issue_cnt_r <= '0;
      p1_r        <= 1'b0;
      p2_r        <= 1'b0;
      p3_r        <= 1'b0;
      p4_r        <= 1'b0;
      p5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        if (store_ok) begin
          cnt_r   <= cnt_r + CNT_W'(1);
          sum_x_r <= sum_x_r + SUM_W'(in_x_coord);
          sum_y_r <= sum_y_r + SUM_W'(in_y_coord);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (pass_done) begin
        issue_cnt_r <= '0;
      end else if (mem_re) begin
        issue_cnt_r <= issue_cnt_r + CNT_W'(1);
      end
      p1_r <= mem_re;
      p2_r <= p1_r;
      p3_r <= p2_r;
      p4_r <= p3_r;
      p5_r <= p4_r;
      // a new result may replace one taken at the same edge
      if (state_r == ST_FIN && state_nxt == ST_IDLE) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_FIN && state_nxt == ST_IDLE) begin
        cnt_r       <= '0;
        sum_x_r     <= '0;
        sum_y_r     <= '0;
        ovf_r       <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- pass pipeline
  always_ff @(posedge clk) begin
    if (p1_r) begin
      dx_r <= 33'(rd_x) - 33'(mx_r);
      dy_r <= 33'(rd_y) - 33'(my_r);
    end
    if (p2_r) begin
      pxx_r <= ux * ux;
      pyy_r <= uy * uy;
      pxy_r <= dx_r * dy_r;
      pa_r  <= dy_r * dir_x_r;
      pb_r  <= dx_r * dir_y_r;
    end
    if (p3_r) begin
      d_r <= pr[DIR_FRAC+D_W-1:DIR_FRAC];
    end
    if (p4_r) begin
      dsq_r <= d_r * d_r;
    end
  end

  // ---------------------------------------------------------------- fit datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_START) begin
      mx_r    <= '0;
      my_r    <= '0;
      dir_x_r <= signed'(DIR_ONE);
      dir_y_r <= '0;
      rms_r   <= '0;
      worst_r <= '0;
      sxx_r   <= '0;
      syy_r   <= '0;
      sxy_r   <= '0;
      ssq_r   <= '0;
    end
    if (state_r == ST_MEAN_X && div_sts.done) begin
      mx_r <= sum_x_r[SUM_W-1] ? -signed'(div_quo[31:0]) : signed'(div_quo[31:0]);
    end
    if (state_r == ST_MEAN_Y && div_sts.done) begin
      my_r <= sum_y_r[SUM_W-1] ? -signed'(div_quo[31:0]) : signed'(div_quo[31:0]);
    end
    if (state_r == ST_MOM && p3_r) begin
      sxx_r <= sxx_r + ACC_W'(pxx_r);
      syy_r <= syy_r + ACC_W'(pyy_r);
      sxy_r <= sxy_r + ACC_W'(pxy_r);
    end
    if (state_r == ST_MOM && pass_done) begin
      a_r    <= sxx_r;
      b_r    <= syy_r;
      c_r    <= sxy_mag;
      cneg_r <= sxy_r[ACC_W-1];
      // zero cross moment: pick the axis with the larger spread, x on a tie
      if (czero && sxx_r < syy_r) begin
        dir_x_r <= '0;
        dir_y_r <= signed'(DIR_ONE);
      end
    end
    if (state_r == ST_SCALE) begin
      if (scale_hi) begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        c_r <= c_r >> 1;
      end else if (!or_all[SCALE_BITS-1]) begin
        a_r <= a_r << 1;
        b_r <= b_r << 1;
        c_r <= c_r << 1;
      end
    end
    if (state_r == ST_SQ) begin
      dd_r  <= diff * diff;
      csq_r <= c_r[SCALE_BITS-1:0] * c_r[SCALE_BITS-1:0];
    end
    if (state_r == ST_DISC && sqrt_sts.done) begin
      disc_r <= sqrt_root;
    end
    if (state_r == ST_VEC) begin
      vx_r <= vx_c;
      vy_r <= vy_c;
    end
    if (state_r == ST_VSQ) begin
      vxsq_r <= vxm * vxm;
      vysq_r <= vym * vym;
    end
    if (state_r == ST_NORM && sqrt_sts.done) begin
      norm_r <= sqrt_root;
    end
    if (state_r == ST_UX && div_sts.done) begin
      dir_x_r <= unit_fix(div_quo, vx_r[32]);
    end
    if (state_r == ST_UY && div_sts.done) begin
      dir_y_r <= unit_fix(div_quo, vy_r[32]);
    end
    if (state_r == ST_RES && p4_r && d_r > worst_r) begin
      worst_r <= d_r;
    end
    if (state_r == ST_RES && p5_r) begin
      ssq_r <= ssq_r + NW'(dsq_r);
    end
    if (state_r == ST_RMS_DIV && div_sts.done && |div_quo[NW-1:SQ_W]) begin
      rms_r <= SAT32;
    end
    if (state_r == ST_RMS_SQRT && sqrt_sts.done) begin
      rms_r <= sqrt_root;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && state_nxt == ST_IDLE) begin
      o_ok_r    <= cnt_r >= CNT_W'(2);
      o_cx_r    <= mx_r;
      o_cy_r    <= my_r;
      o_dx_r    <= (cnt_r >= CNT_W'(2)) ? dir_x_r : '0;
      o_dy_r    <= (cnt_r >= CNT_W'(2)) ? dir_y_r : '0;
      o_rms_r   <= rms_r;
      o_max_r   <= (|worst_r[D_W-1:32]) ? SAT32 : worst_r[31:0];
      o_cnt_r   <= cnt_r;
      o_trunc_r <= ovf_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_fit_ok      = o_ok_r;
  assign out_centroid_x  = o_cx_r;
  assign out_centroid_y  = o_cy_r;
  assign out_dir_x       = o_dx_r;
  assign out_dir_y       = o_dy_r;
  assign out_rms_dev     = o_rms_r;
  assign out_max_dev     = o_max_r;
  assign out_point_count = o_cnt_r;
  assign out_truncated   = o_trunc_r;

  // ---------------------------------------------------------------- checks
  `TLS_CHECK(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(MAX_POINTS), "point count past capacity")
  `TLS_IMPLY(a_pipe_in_pass, clk, rst_n, p1_r, pass_on, "store read outside a pass")
  `TLS_IMPLY(a_div_idle, clk, rst_n, div_start, !div_sts.busy, "divider restarted while busy")
  `TLS_IMPLY(a_sqrt_idle, clk, rst_n, sqrt_start, !sqrt_sts.busy, "square root restarted")
  `TLS_IMPLY(a_run_cleared, clk, rst_n, $rose(out_valid_r), cnt_r == '0, "run not cleared")

endmodule

@@ rtl/core/tls_mem.sv @@
// Point store: one write port, one registered read port.
module tls_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/tls_div.sv @@
// Restoring divider, one quotient bit per cycle.
module tls_div #(
  parameter int NW = 78
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [NW-1:0]             num,
  input  logic [tls_pkg::DEN_W-1:0] den,
  output logic [NW-1:0]             quo,
  output tls_pkg::unit_sts_t        sts
);
  import tls_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]    num_r;
  logic [NW-1:0]    quo_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_nxt;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_r[DEN_W-1:0], num_r[NW-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? rem_sh - {1'b0, den_r} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_r << 1;
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

  assign quo = quo_r;
  assign sts = '{busy: busy_r, done: done_r};

endmodule

@@ rtl/core/tls_sqrt.sv @@
// Floor square root, two radicand bits per cycle.
module tls_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tls_pkg::SQ_W-1:0]   rad,
  output logic [tls_pkg::ROOT_W-1:0] root,
  output tls_pkg::unit_sts_t         sts
);
  import tls_pkg::*;

  logic [SQ_W-1:0] v_r;
  logic [SQ_W-1:0] r_r;
  logic [SQ_W-1:0] bit_r;
  logic            busy_r;
  logic            done_r;
  logic [SQ_W-1:0] trial;
  logic            ge;

  always_comb begin
    trial = r_r + bit_r;
    ge    = v_r >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r == SQ_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= rad;
      r_r   <= '0;
      bit_r <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy_r) begin
      if (ge) begin
        v_r <= v_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign root = r_r[ROOT_W-1:0];
  assign sts  = '{busy: busy_r, done: done_r};

endmodule

@@ sim/tb_total_least_squares_line_fit.sv @@
// Testbench for the total least squares line fit: directed table, random runs, scoreboard.
module tb_total_least_squares_line_fit;
  import tls_pkg::*;

  localparam int NPTS = 1024;
  localparam logic [31:0] MAXU = 32'hFFFF_FFFF;
  localparam logic signed [31:0] CMIN = 32'sh8000_0000;
  localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;

  // One fit result, field by field as on the ports.
  typedef struct {
    bit          fit_ok;
    logic [31:0] cen_x;
    logic [31:0] cen_y;
    logic [31:0] dir_x;
    logic [31:0] dir_y;
    logic [31:0] rms;
    logic [31:0] worst;
    logic [10:0] count;
    bit          trunc;
  } fit_t;

  // Directed row: a point, plus a hand-written result where one is obvious.
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    bit                 last;
    bit                 typed;
    fit_t               res;
  } row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [31:0]       in_x_coord = '0;
  logic signed [31:0]       in_y_coord = '0;
  logic                     in_last_point = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_fit_ok;
  logic signed [31:0]       out_centroid_x;
  logic signed [31:0]       out_centroid_y;
  logic signed [31:0]       out_dir_x;
  logic signed [31:0]       out_dir_y;
  logic [31:0]              out_rms_dev;
  logic [31:0]              out_max_dev;
  logic [10:0]              out_point_count;
  logic                     out_truncated;

  total_least_squares_line_fit #(.MAX_POINTS(NPTS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_x_coord(in_x_coord), .in_y_coord(in_y_coord), .in_last_point(in_last_point),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_fit_ok(out_fit_ok), .out_centroid_x(out_centroid_x),
    .out_centroid_y(out_centroid_y), .out_dir_x(out_dir_x), .out_dir_y(out_dir_y),
    .out_rms_dev(out_rms_dev), .out_max_dev(out_max_dev),
    .out_point_count(out_point_count), .out_truncated(out_truncated)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the block's point store and running sums.
  logic signed [31:0] pt_x [NPTS];
  logic signed [31:0] pt_y [NPTS];
  int                 pt_cnt;
  longint             acc_x, acc_y;
  bit                 dropped;

  fit_t  fit_q[$];
  row_t  tab[$];
  int    errors;
  int    n_items, n_fits, n_trunc, n_short;
  bit    quiet;     // no idling on either side
  bit    hold_req;  // ask the receiver for a long hold-off

  // Floor square root, bit by bit.
  function automatic logic [63:0] sqrt_floor(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] mag(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint mean_round(longint s, int n);
    logic [63:0] q;
    q = (mag(s) + 64'(n / 2)) / 64'(n);
    return (s < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic int bit_len(logic [127:0] v);
    int k;
    for (k = 127; k >= 0; k--) if (v[k]) return k + 1;
    return 0;
  endfunction

  function automatic logic [63:0] rescale(logic [127:0] v, int sh);
    logic [127:0] t;
    t = (sh <= 0) ? (v << (-sh)) : (v >> sh);
    return t[63:0];
  endfunction

  function automatic longint unit_part(logic [63:0] m, logic [63:0] nrm, bit neg);
    logic [63:0] q;
    q = ((m << 30) + nrm / 2) / nrm;
    if (q > 64'(DIR_ONE)) q = 64'(DIR_ONE);
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // Closes the current run: centroid, direction, residuals, then clears.
  function automatic fit_t line_fit();
    fit_t        r;
    int          n, i, sh, bl;
    longint      mx, my, dx, dy, ux_d, uy_d, diff, vx, vy, p;
    logic [63:0] ux, uy, a, b, cm, disc, nrm, d, rt;
    logic [127:0] sxx, syy, spos, sneg, sxy, ssq, q;
    bit          cneg;
    r = '{default: 0};
    n = pt_cnt;
    r.count = 11'(n);
    r.trunc = dropped;
    if (n >= 2) begin
      r.fit_ok = 1;
      mx = mean_round(acc_x, n);
      my = mean_round(acc_y, n);
      sxx = 0; syy = 0; spos = 0; sneg = 0;
      for (i = 0; i < n; i++) begin
        dx = longint'(pt_x[i]) - mx;
        dy = longint'(pt_y[i]) - my;
        ux = mag(dx);
        uy = mag(dy);
        sxx += 128'(ux) * 128'(ux);
        syy += 128'(uy) * 128'(uy);
        if ((dx < 0) != (dy < 0)) sneg += 128'(ux) * 128'(uy);
        else spos += 128'(ux) * 128'(uy);
      end
      cneg = spos < sneg;
      sxy = cneg ? sneg - spos : spos - sneg;
      ux_d = longint'(DIR_ONE);
      uy_d = 0;
      if (sxy == 0) begin
        // no cross moment: pick the wider axis, x on a tie
        if (sxx < syy) begin
          ux_d = 0;
          uy_d = longint'(DIR_ONE);
        end
      end else begin
        bl = bit_len(sxx);
        if (bit_len(syy) > bl) bl = bit_len(syy);
        if (bit_len(sxy) > bl) bl = bit_len(sxy);
        sh = bl - SCALE_BITS;
        a = rescale(sxx, sh);
        b = rescale(syy, sh);
        cm = rescale(sxy, sh);
        diff = longint'(a) - longint'(b);
        disc = sqrt_floor(64'(diff * diff) + 4 * cm * cm);
        if (diff >= 0) begin
          vx = diff + longint'(disc);
          vy = cneg ? -longint'(2 * cm) : longint'(2 * cm);
        end else begin
          vx = longint'(2 * cm);
          vy = longint'(disc) - diff;
          if (cneg) vy = -vy;
        end
        nrm = sqrt_floor(64'(vx * vx) + 64'(vy * vy));
        if (nrm != 0) begin
          ux_d = unit_part(mag(vx), nrm, vx < 0);
          uy_d = unit_part(mag(vy), nrm, vy < 0);
        end
      end
      ssq = 0;
      d = 0;
      for (i = 0; i < n; i++) begin
        dx = longint'(pt_x[i]) - mx;
        dy = longint'(pt_y[i]) - my;
        p = dy * ux_d - dx * uy_d;
        rt = (mag(p) + (64'd1 << 29)) >> 30;
        if (rt > d) d = rt;
        ssq += 128'(rt) * 128'(rt);
      end
      q = ssq / 128'(n);
      rt = (q[127:64] != 0) ? 64'(MAXU) : sqrt_floor(q[63:0]);
      if (rt > 64'(MAXU)) rt = 64'(MAXU);
      if (d > 64'(MAXU)) d = 64'(MAXU);
      r.cen_x = mx[31:0];
      r.cen_y = my[31:0];
      r.dir_x = ux_d[31:0];
      r.dir_y = uy_d[31:0];
      r.rms = rt[31:0];
      r.worst = d[31:0];
    end
    pt_cnt = 0;
    acc_x = 0;
    acc_y = 0;
    dropped = 0;
    return r;
  endfunction

  // Takes one accepted point into the shadow store.
  function automatic void store_point(logic signed [31:0] x, logic signed [31:0] y);
    if (pt_cnt < NPTS) begin
      pt_x[pt_cnt] = x;
      pt_y[pt_cnt] = y;
      pt_cnt++;
      acc_x += longint'(x);
      acc_y += longint'(y);
    end else begin
      dropped = 1;
    end
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h (fit %0d)", what, got, want, n_fits);
    errors++;
  endtask

  // Drives one item; valid stays up across back-to-back items.
  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, bit last,
                            bit typed, fit_t tres);
    int   gap;
    fit_t r;
    gap = 0;
    if (!quiet && ($urandom % 4 == 0)) gap = $urandom_range(1, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_coord <= x;
    in_y_coord <= y;
    in_last_point <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
    store_point(x, y);
    if (last) begin
      r = line_fit();
      fit_q.push_back(typed ? tres : r);
    end
  endtask

  function automatic void add_row(logic signed [31:0] x, logic signed [31:0] y, bit last);
    row_t w;
    w = '{x: x, y: y, last: last, typed: 0, res: '{default: 0}};
    tab.push_back(w);
  endfunction

  function automatic void add_known(logic signed [31:0] x, logic signed [31:0] y, fit_t r);
    row_t w;
    w = '{x: x, y: y, last: 1, typed: 1, res: r};
    tab.push_back(w);
  endfunction

  // One run of random points. kind 0: anywhere; 1: near a line; 2: tight cluster.
  task automatic send_run(int len, int kind);
    int      i;
    longint  x0, y0, stp, slope, nx, ny;
    logic signed [31:0] x, y;
    fit_t    none;
    none = '{default: 0};
    x0 = longint'($signed($urandom)) >>> $urandom_range(0, 8);
    y0 = longint'($signed($urandom)) >>> $urandom_range(0, 8);
    stp = $urandom_range(1, (len > 64) ? 4096 : 65536 * 4);
    slope = longint'($urandom_range(0, 1 << 19)) - (1 << 18);
    for (i = 0; i < len; i++) begin
      nx = longint'($urandom_range(0, 1023)) - 512;
      ny = longint'($urandom_range(0, 1023)) - 512;
      case (kind)
        0: begin
          x = $urandom;
          y = $urandom;
        end
        1: begin
          x = 32'(x0 + i * stp + nx);
          y = 32'(y0 + ((i * stp * slope) >>> 16) + ny);
        end
        default: begin
          x = 32'(x0 + (nx >>> $urandom_range(0, 9)));
          y = 32'(y0 + (ny >>> $urandom_range(0, 9)));
        end
      endcase
      send_point(x, y, i == len - 1, 0, none);
    end
  endtask

  // Scoreboard: each result against the oldest expectation.
  always @(posedge clk) begin
    fit_t e;
    if (rst_n && out_valid && out_ready) begin
      if (fit_q.size() == 0) begin
        $display("unexpected result, nothing outstanding");
        errors++;
      end else begin
        e = fit_q.pop_front();
        if (out_fit_ok != e.fit_ok) report("fit_ok", 32'(out_fit_ok), 32'(e.fit_ok));
        if (out_centroid_x != e.cen_x) report("centroid_x", out_centroid_x, e.cen_x);
        if (out_centroid_y != e.cen_y) report("centroid_y", out_centroid_y, e.cen_y);
        if (out_dir_x != e.dir_x) report("dir_x", out_dir_x, e.dir_x);
        if (out_dir_y != e.dir_y) report("dir_y", out_dir_y, e.dir_y);
        if (out_rms_dev != e.rms) report("rms_dev", out_rms_dev, e.rms);
        if (out_max_dev != e.worst) report("max_dev", out_max_dev, e.worst);
        if (out_point_count != e.count)
          report("point_count", 32'(out_point_count), 32'(e.count));
        if (out_truncated != e.trunc) report("truncated", 32'(out_truncated), 32'(e.trunc));
        n_fits++;
        if (e.trunc) n_trunc++;
        if (!e.fit_ok) n_short++;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (4000) @(posedge clk);
        hold_req = 0;
        out_ready <= 1'b1;
      end else if (!quiet && ($urandom % 4 == 0)) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", fit_q.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    int r, len, kind;
    row_t w;
    errors = 0; n_items = 0; n_fits = 0; n_trunc = 0; n_short = 0;
    quiet = 0; hold_req = 0;
    pt_cnt = 0; acc_x = 0; acc_y = 0; dropped = 0;

    // Directed table.
    add_known(5, 7, '{0, 0, 0, 0, 0, 0, 0, 1, 0});                  // lone point
    add_row(100, -100, 0);                                          // coincident pair
    add_known(100, -100, '{1, 100, -100, DIR_ONE, 0, 0, 0, 2, 0});
    add_row(0, 0, 0);                                               // flat line
    add_known(2, 0, '{1, 1, 0, DIR_ONE, 0, 0, 0, 2, 0});
    add_row(0, -3, 0);                                              // vertical line
    add_known(0, 3, '{1, 0, 0, 0, DIR_ONE, 0, 0, 2, 0});
    add_row(1, 0, 0);                                               // equal spread, no cross
    add_row(-1, 0, 0);
    add_row(0, 1, 0);
    add_known(0, -1, '{1, 0, 0, DIR_ONE, 0, 0, 1, 4, 0});
    add_row(CMIN, CMIN, 0);                                         // extremes
    add_row(CMAX, CMAX, 1);
    add_row(CMIN, CMAX, 0);
    add_row(CMAX, CMIN, 1);
    add_row(CMIN, CMIN, 0);                                         // four corners
    add_row(CMAX, CMIN, 0);
    add_row(CMIN, CMAX, 0);
    add_row(CMAX, CMAX, 1);
    add_row(0, 0, 0);                                               // rising diagonal
    add_row(65536, 65536, 0);
    add_row(131072, 131072, 1);
    add_row(0, 0, 0);                                               // falling diagonal
    add_row(65536, -65536, 1);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (tab[k]) begin
      w = tab[k];
      send_point(w.x, w.y, w.last, w.typed, w.res);
    end

    // Random runs; an early long one overflows the store and drops its final two points.
    for (r = 0; n_items < 1250; r++) begin
      if (r == 10) hold_req = 1;
      if (r == 25) begin
        in_valid <= 1'b0;
        while (fit_q.size() != 0) @(posedge clk);
      end
      if (r == 12) begin
        send_run(NPTS + 2, 1);
      end else begin
        len = ($urandom % 8 == 0) ? $urandom_range(1, 2) : $urandom_range(2, 12);
        kind = $urandom_range(0, 9);
        send_run(len, (kind < 2) ? 0 : (kind < 8) ? 1 : 2);
      end
      if (n_items > 1150) quiet = 1;
    end
    in_valid <= 1'b0;

    while (fit_q.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);

    $display("%0d points in %0d fits: %0d short runs, %0d truncated, %0d mismatches",
             n_items, n_fits, n_short, n_trunc, errors);
    $display("covered extremes, axis and tie cases, random lines and clusters, back-pressure");
    if (errors == 0 && fit_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
